[src/rmc_pkg.sv]
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types and constants for the range match MRU cache.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int WAYS_DEF    = 4;
  localparam int ID_BITS_DEF = 16;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [15:0] region_id;
    logic [31:0] region_start;
    logic [31:0] region_end;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] hit_region;
    logic [1:0]  hit_way;
  } out_t;

  // Broadcast to every cell in the chain for one transaction.
  typedef struct packed {
    logic        fill;
    logic        stale;
    logic [31:0] address;
  } cmd_t;

endpackage

[src/rmc_cell.sv]
// ----------------------------------------------------------------------------
// rmc_cell
// One cache entry: holds region id and range, compares against the broadcast
// command and takes its neighbor's entry when a fill shifts the chain.
// ----------------------------------------------------------------------------
module rmc_cell #(
  parameter int ID_BITS = rmc_pkg::ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmc_pkg::cmd_t        cmd_i,
  input  logic [ID_BITS-1:0]   id_i,
  input  logic                 hold_i,
  input  logic                 prev_valid_i,
  input  logic [ID_BITS-1:0]   prev_region_i,
  input  logic [31:0]          prev_low_i,
  input  logic [31:0]          prev_high_i,
  output logic                 valid_o,
  output logic [ID_BITS-1:0]   region_o,
  output logic [31:0]          low_o,
  output logic [31:0]          high_o,
  output logic                 match_o,
  output logic                 hit_o
);

  logic               valid_q, valid_d;
  logic [ID_BITS-1:0] region_q, region_d;
  logic [31:0]        low_q, low_d;
  logic [31:0]        high_q, high_d;
  logic               load;

  // A stale cache reads as empty.
  assign valid_o  = valid_q & ~cmd_i.stale;
  assign region_o = region_q;
  assign low_o    = low_q;
  assign high_o   = high_q;

  assign match_o = valid_o && (region_q == id_i);
  assign hit_o   = valid_o && (cmd_i.address >= low_q) && (cmd_i.address < high_q);

  assign load = cmd_i.fill & ~hold_i;

  always_comb begin
    valid_d  = valid_q;
    region_d = region_q;
    low_d    = low_q;
    high_d   = high_q;
    if (cmd_i.fill) begin
      valid_d = valid_o;
      if (load) begin
        valid_d  = prev_valid_i;
        region_d = prev_region_i;
        low_d    = prev_low_i;
        high_d   = prev_high_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
    low_q    <= low_d;
    high_q   <= high_d;
  end

endmodule

[src/range_match_mru_cache_core.sv]
// ----------------------------------------------------------------------------
// range_match_mru_cache_core
// Fully associative MRU cache of address ranges built as a chain of entries.
// ----------------------------------------------------------------------------
// Every transaction (lookup, fill or invalidate) produces exactly one result,
// registered in the cycle after acceptance; a new transaction can be accepted in
// every cycle while the result register is free or being drained. Lookups
// return the lowest-position entry whose range contains the address; fills
// and invalidates return an all-zero result. The cycle is bounded by the
// per-entry range compares and the priority select across the WAYS entries.
// ----------------------------------------------------------------------------
module range_match_mru_cache_core #(
  parameter int WAYS    = rmc_pkg::WAYS_DEF,
  parameter int ID_BITS = rmc_pkg::ID_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmc_pkg::out_t out_data_o
);

  logic               in_acc;
  rmc_pkg::mode_e     mode;
  logic               is_fill, is_lookup, is_inval;
  logic               stale_q, stale_d;
  rmc_pkg::cmd_t      cmd;
  logic [ID_BITS-1:0] fill_id;

  logic               cell_valid [WAYS];
  logic [ID_BITS-1:0] cell_region [WAYS];
  logic [31:0]        cell_low [WAYS];
  logic [31:0]        cell_high [WAYS];
  logic [WAYS-1:0]    cell_match;
  logic [WAYS-1:0]    cell_hit;
  logic [WAYS-1:0]    hold;
  logic [WAYS-1:0]    seen;

  rmc_pkg::out_t      res;
  rmc_pkg::out_t      out_q, out_d;
  logic               out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign mode = rmc_pkg::mode_e'(in_data_i.mode);

  always_comb begin
    is_fill   = 1'b0;
    is_lookup = 1'b0;
    is_inval  = 1'b0;
    case (mode)
      rmc_pkg::MODE_LOOKUP: is_lookup = 1'b1;
      rmc_pkg::MODE_FILL:   is_fill   = 1'b1;
      rmc_pkg::MODE_INVAL:  is_inval  = 1'b1;
      default: ;
    endcase
  end

  assign fill_id = ID_BITS'(in_data_i.region_id);

  always_comb begin
    cmd.fill    = in_acc & is_fill;
    cmd.stale   = stale_q;
    cmd.address = in_data_i.address;
  end

  always_comb begin
    stale_d = stale_q;
    if (in_acc && is_inval) begin
      stale_d = 1'b1;
    end else if (in_acc && is_fill) begin
      stale_d = 1'b0;
    end
  end

  // Chain of entries. A cell shifts in its neighbor's entry on a fill unless
  // the id was already found above it; the front cell also holds on its own
  // match.
  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign hold[g] = cell_match[g];
      rmc_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .id_i          (fill_id),
        .hold_i        (hold[g]),
        .prev_valid_i  (1'b1),
        .prev_region_i (fill_id),
        .prev_low_i    (in_data_i.region_start),
        .prev_high_i   (in_data_i.region_end),
        .valid_o       (cell_valid[g]),
        .region_o      (cell_region[g]),
        .low_o         (cell_low[g]),
        .high_o        (cell_high[g]),
        .match_o       (cell_match[g]),
        .hit_o         (cell_hit[g])
      );
    end else begin : g_body
      assign hold[g] = seen[g-1];
      rmc_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .id_i          (fill_id),
        .hold_i        (hold[g]),
        .prev_valid_i  (cell_valid[g-1]),
        .prev_region_i (cell_region[g-1]),
        .prev_low_i    (cell_low[g-1]),
        .prev_high_i   (cell_high[g-1]),
        .valid_o       (cell_valid[g]),
        .region_o      (cell_region[g]),
        .low_o         (cell_low[g]),
        .high_o        (cell_high[g]),
        .match_o       (cell_match[g]),
        .hit_o         (cell_hit[g])
      );
    end
    assign seen[g] = hold[g] | cell_match[g];
  end

  // First hit wins: scan from the back so the lowest position lands last.
  always_comb begin
    res = '0;
    if (is_lookup) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (cell_hit[i]) begin
          res.hit        = 1'b1;
          res.hit_region = 16'(cell_region[i]);
          res.hit_way    = 2'(i);
        end
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A fill always leaves a live entry at the front and clears the stale mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_fill) |=> (!stale_q && cell_valid[0]))
    else $error("fill did not leave a valid front entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_inval) |=> stale_q)
    else $error("invalidate did not mark cache stale");

  // A stale cache must never report a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stale_q) |=> (out_valid_o && !out_data_o.hit))
    else $error("hit reported while cache stale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.hit_region == 16'd0 && out_data_o.hit_way == 2'd0))
    else $error("miss result carries nonzero fields");

endmodule
